// ===== src/sbd_pkg.sv =====
// Shared constants, types and blend functions for the scanline box downscaler.
`default_nettype none

package sbd_pkg;

  localparam int unsigned LINE_W   = 8;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned XCOL_W   = 8;
  localparam int unsigned ROW_W    = 7;

  localparam int unsigned OUT_WIDTH  = 160;
  localparam int unsigned FIRST_LINE = 8;
  localparam int unsigned END_LINE   = 232;
  localparam int unsigned LINE_LIMIT = 240;

  localparam logic [PIX_W-1:0] BLEND_MASK = 16'hF7DE;

  // floor(v / 7) == (v * 293) >> 11 for every 8-bit v
  localparam int unsigned Div7Mul   = 293;
  localparam int unsigned Div7Shift = 11;

  typedef logic [PIX_W-1:0] pixel_t;

  // position of a kept line inside its group of seven
  typedef enum logic [2:0] {
    PH_DIRECT  = 3'd0,
    PH_STORE_A = 3'd1,
    PH_NEAR    = 3'd2,
    PH_STORE_B = 3'd3,
    PH_MID     = 3'd4,
    PH_STORE_C = 3'd5,
    PH_FAR     = 3'd6
  } vphase_e;

  // carry-free 565 average: drop each field's LSB before the shift
  function automatic pixel_t half_mix(input pixel_t a, input pixel_t b);
    pixel_t diff;
    diff = (a ^ b) & BLEND_MASK;
    return (diff >> 1) + (a & b);
  endfunction

  function automatic pixel_t swap_bytes(input pixel_t v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [5:0] div7(input logic [7:0] v);
    logic [16:0] prod;
    prod = 17'(v) * 17'(Div7Mul);
    return prod[16:Div7Shift];
  endfunction

endpackage

`default_nettype wire

// ===== src/sbd_in_if.sv =====
// Source-pixel channel: valid/ready with line, column and pixel payload.
`default_nettype none

interface sbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbd_pkg::LINE_W-1:0]   src_line;
  logic [sbd_pkg::COL_W-1:0]    src_column;
  logic [sbd_pkg::PIX_W-1:0]    src_pixel;

  modport source (output valid, src_line, src_column, src_pixel, input ready);
  modport sink   (input valid, src_line, src_column, src_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/sbd_out_if.sv =====
// Result channel: valid/ready with scaled pixel, column, row and row-end flag.
`default_nettype none

interface sbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbd_pkg::PIX_W-1:0]    out_pixel;
  logic [sbd_pkg::XCOL_W-1:0]   out_column;
  logic [sbd_pkg::ROW_W-1:0]    out_row;
  logic                         row_end;

  modport source (output valid, out_pixel, out_column, out_row, row_end, input ready);
  modport sink   (input valid, out_pixel, out_column, out_row, row_end, output ready);
endinterface

`default_nettype wire

// ===== src/scanline_box_downscaler_core.sv =====
// Top level: 8:5 horizontal, 7:4 vertical box downscaler around one line store.
// A result beat passes the stage 1 register, then the output register, after its source beat is accepted.
// Throughput: one source pixel per cycle unless the result channel stalls; the line store does one read
// or one write per accepted beat, so pixels stream back to back without a bubble.
// Reset (rst_ni low, async) clears the pipeline valids and the previous pixel.
// The line store is not cleared; blend rows read only entries a store row wrote.
`default_nettype none

module scanline_box_downscaler_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sbd_in_if.sink      src_i,
  sbd_out_if.source   res_o
);
  import sbd_pkg::*;

  // column taps inside a group of eight source columns
  localparam logic [2:0] TAP_COPY  = 3'd0;
  localparam logic [2:0] TAP_HALF  = 3'd2;
  localparam logic [2:0] TAP_QTR_P = 3'd4;
  localparam logic [2:0] TAP_QTR_C = 3'd5;
  localparam logic [2:0] TAP_LAST  = 3'd7;

  // ---------------------------------------------------------------
  // Stage 0: horizontal blend, position decode, line store access
  // ---------------------------------------------------------------
  pixel_t prev_pixel_q;

  logic              accept;
  logic              line_ok;
  logic              tap_ok;
  logic [2:0]        slot;
  pixel_t            mix_pc;
  pixel_t            h_pix;
  logic [XCOL_W-1:0] x_col;
  logic              x_ok;
  logic [LINE_W-1:0] rel;
  logic [5:0]        grp;
  logic [2:0]        phase_raw;
  vphase_e           phase;
  logic [ROW_W-1:0]  row;
  logic              kept;
  logic              emit;
  logic              store_wr;

  always_comb begin
    line_ok = (src_i.src_line < LINE_W'(LINE_LIMIT)) &&
              (src_i.src_line >= LINE_W'(FIRST_LINE)) &&
              (src_i.src_line < LINE_W'(END_LINE));

    mix_pc = half_mix(prev_pixel_q, src_i.src_pixel);
    tap_ok = 1'b1;
    slot   = 3'd0;
    h_pix  = src_i.src_pixel;
    case (src_i.src_column[2:0])
      TAP_COPY: begin
        slot  = 3'd0;
        h_pix = src_i.src_pixel;
      end
      TAP_HALF: begin
        slot  = 3'd1;
        h_pix = mix_pc;
      end
      TAP_QTR_P: begin
        slot  = 3'd2;
        h_pix = half_mix(prev_pixel_q, mix_pc);
      end
      TAP_QTR_C: begin
        slot  = 3'd3;
        h_pix = half_mix(src_i.src_pixel, mix_pc);
      end
      TAP_LAST: begin
        slot  = 3'd4;
        h_pix = mix_pc;
      end
      default: begin
        tap_ok = 1'b0;
      end
    endcase

    // x = 5 * (column / 8) + slot
    x_col = XCOL_W'({src_i.src_column[7:3], 2'b00}) + XCOL_W'(src_i.src_column[7:3]) +
            XCOL_W'(slot);
    x_ok  = x_col < XCOL_W'(OUT_WIDTH);

    // group of seven lines and phase within it
    rel       = src_i.src_line - LINE_W'(FIRST_LINE);
    grp       = div7(rel);
    phase_raw = 3'(rel - LINE_W'({grp, 3'b000}) + LINE_W'(grp));
    phase     = vphase_e'(phase_raw);
    row       = ROW_W'({grp, 2'b00}) + ROW_W'(phase_raw[2:1]);

    kept     = accept && line_ok && tap_ok && x_ok;
    emit     = kept && !phase_raw[0];
    store_wr = kept && phase_raw[0];
  end

  // ---------------------------------------------------------------
  // Handshake: stage 1 register and output register
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv;

  assign out_adv     = !out_valid_q || res_o.ready;
  assign src_i.ready = !s1_valid_q || out_adv;
  assign accept      = src_i.valid && src_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = emit;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pixel_q <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        prev_pixel_q <= src_i.src_pixel;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------
  // Line store: one 160 x 16 memory, single access per beat.
  // Store rows write, blend rows read; a beat never does both, and a read
  // issued the cycle after a write to the same entry already sees it.
  // ---------------------------------------------------------------
  pixel_t line_store [OUT_WIDTH];
  pixel_t rd_q;

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      line_store[x_col] <= h_pix;
    end
    if (emit) begin
      rd_q <= line_store[x_col];
    end
  end

  // stage 1 payload, loaded with every accepted beat
  pixel_t            s1_h_q;
  logic [XCOL_W-1:0] s1_x_q;
  logic [ROW_W-1:0]  s1_row_q;
  vphase_e           s1_phase_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_h_q     <= h_pix;
      s1_x_q     <= x_col;
      s1_row_q   <= row;
      s1_phase_q <= phase;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: vertical blend against the stored line
  // ---------------------------------------------------------------
  pixel_t v_mid;
  pixel_t v_pix;

  always_comb begin
    v_mid = half_mix(rd_q, s1_h_q);
    case (s1_phase_q)
      PH_DIRECT: v_pix = s1_h_q;
      PH_NEAR:   v_pix = half_mix(s1_h_q, v_mid);  // 25% stored
      PH_MID:    v_pix = v_mid;                    // 50/50
      PH_FAR:    v_pix = half_mix(rd_q, v_mid);    // 75% stored
      default:   v_pix = s1_h_q;
    endcase
  end

  pixel_t            out_pixel_q;
  logic [XCOL_W-1:0] out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_end_q;

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_pixel_q <= swap_bytes(v_pix);
      out_col_q   <= s1_x_q;
      out_row_q   <= s1_row_q;
      out_end_q   <= s1_x_q == XCOL_W'(OUT_WIDTH - 1);
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_pixel  = out_pixel_q;
  assign res_o.out_column = out_col_q;
  assign res_o.out_row    = out_row_q;
  assign res_o.row_end    = out_end_q;

endmodule

`default_nettype wire

// ===== src/sbd_port_checker.sv =====
// Port-level assertions for the downscaler core, bound onto the top level.
`default_nettype none

module sbd_port_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic [sbd_pkg::PIX_W-1:0]          out_pixel_i,
  input wire logic [sbd_pkg::XCOL_W-1:0]         out_column_i,
  input wire logic [sbd_pkg::ROW_W-1:0]          out_row_i,
  input wire logic                               row_end_i
);
  import sbd_pkg::*;

  // stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i) &&
      $stable(out_column_i) && $stable(out_row_i) && $stable(row_end_i))
    else $error("result beat changed while stalled");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_column_i < XCOL_W'(OUT_WIDTH))
    else $error("output column beyond row width");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> row_end_i == (out_column_i == XCOL_W'(OUT_WIDTH - 1)))
    else $error("row_end disagrees with column");

  // a fresh result follows an accepted source beat through the stage 1 and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result beat without matching source beat");

endmodule

bind scanline_box_downscaler_core sbd_port_checker u_sbd_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (src_i.valid),
  .in_ready_i   (src_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_pixel_i  (res_o.out_pixel),
  .out_column_i (res_o.out_column),
  .out_row_i    (res_o.out_row),
  .row_end_i    (res_o.row_end)
);

`default_nettype wire
